>>> rtl/u16u8_pkg.sv
package u16u8_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int LIMIT_WIDTH = 16;
    localparam int WRITTEN_WIDTH = 16;
    localparam int CMP_WIDTH = (COUNT_WIDTH + 1 > LIMIT_WIDTH) ? COUNT_WIDTH + 1 : LIMIT_WIDTH;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BOM   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [7:0] BOM_HI = 8'hFE;
    localparam logic [7:0] BOM_LO = 8'hFF;

    typedef enum logic [3:0] {
        PH_MARK1   = 4'b0001,
        PH_MARK2   = 4'b0010,
        PH_CONV    = 4'b0100,
        PH_DISCARD = 4'b1000
    } phase_t;

    // All results caused by one input: up to three UTF-8 bytes, then an optional status.
    typedef struct packed {
        logic [2:0][7:0]           data;
        logic [1:0]                num_data;
        logic                      has_status;
        logic [1:0]                code;
        logic [WRITTEN_WIDTH-1:0]  written;
    } bundle_t;

    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      num_data;
    } enc_t;

    function automatic enc_t encode_unit(input logic [15:0] u);
        enc_t e;
        e.data = '0;
        if (u < 16'h0080) begin
            e.data[0]  = u[7:0];
            e.num_data = 2'd1;
        end
        else if (u < 16'h0800) begin
            e.data[0]  = {3'b110, u[10:6]};
            e.data[1]  = {2'b10, u[5:0]};
            e.num_data = 2'd2;
        end
        else begin
            e.data[0]  = {4'b1110, u[15:12]};
            e.data[1]  = {2'b10, u[11:6]};
            e.data[2]  = {2'b10, u[5:0]};
            e.num_data = 2'd3;
        end
        return e;
    endfunction

endpackage

>>> rtl/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 encoder.
// The slave channel takes one message byte per transaction: s_tdata[7:0] is the
// byte and s_tlast marks the last byte of a message. A message opens with a
// byte-order mark (FE FF big-endian, FF FE little-endian); each later byte pair
// is one code unit, sent on the master channel as 1 to 3 UTF-8 bytes. On the
// last byte a status transaction (m_tuser high) follows with the code and the
// count of bytes written. m_tlast marks the last result caused by one input.
// The first result of an input byte passes through the per-input result
// buffer and then the result register on its way to the master channel. An
// input byte with results holds the slave channel while the one-result-wide
// result register drains that buffer; a byte with no result does not hold it.
// The slave side is ready whenever that buffer is empty, so the next byte is
// taken while the last result of the previous one still waits on the master
// side. When the receiver stalls, the result register holds and the buffer
// fills; the slave side then waits. Reset clears the message state, empties
// both registers and sets output_limit to 65535. Write cfg_wdata with cfg_we
// only while no message results are pending.
module utf16_to_utf8_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [9:8] status_code, [25:10] bytes_written
    output logic        m_tuser,   // is_status
    output logic        m_tlast,   // run_last
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata  // output_limit
);
    import u16u8_pkg::*;

    logic [LIMIT_WIDTH-1:0]   limit_reg;
    bundle_t                  conv_bundle;
    logic                     conv_any;
    logic                     accept;

    bundle_t                  bundle_reg;
    logic                     bundle_valid_reg;
    logic [1:0]               ptr_reg;

    logic                     out_valid_reg;
    logic [7:0]               out_byte_reg;
    logic                     out_status_reg;
    logic [1:0]               out_code_reg;
    logic [WRITTEN_WIDTH-1:0] out_written_reg;
    logic                     out_last_reg;

    logic                     out_load;
    logic                     item_is_data;
    logic                     item_last;
    logic [1:0]               last_data_idx;

    assign s_tready = !bundle_valid_reg;
    assign accept   = s_tvalid && s_tready;

    u16u8_conv u_conv (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .in_byte        (s_tdata),
        .end_of_message (s_tlast),
        .output_limit   (limit_reg),
        .bundle         (conv_bundle),
        .bundle_any     (conv_any)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '1;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    assign out_load      = bundle_valid_reg && (!out_valid_reg || m_tready);
    assign item_is_data  = ptr_reg < bundle_reg.num_data;
    assign last_data_idx = bundle_reg.num_data - 2'd1;
    assign item_last     = item_is_data ? (ptr_reg == last_data_idx && !bundle_reg.has_status)
                                        : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bundle_valid_reg <= 1'b0;
            ptr_reg          <= '0;
        end
        else if (accept)
        begin
            bundle_valid_reg <= conv_any;
            ptr_reg          <= '0;
        end
        else if (out_load)
        begin
            if (item_last)
            begin
                bundle_valid_reg <= 1'b0;
                ptr_reg          <= '0;
            end
            else
            begin
                ptr_reg <= ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            bundle_reg <= conv_bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_last_reg <= item_last;
            if (item_is_data)
            begin
                out_byte_reg    <= bundle_reg.data[ptr_reg];
                out_status_reg  <= 1'b0;
                out_code_reg    <= ST_OK;
                out_written_reg <= '0;
            end
            else
            begin
                out_byte_reg    <= '0;
                out_status_reg  <= 1'b1;
                out_code_reg    <= bundle_reg.code;
                out_written_reg <= bundle_reg.written;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_written_reg, out_code_reg, out_byte_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/u16u8_conv.sv
module u16u8_conv (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [7:0]                        in_byte,
    input  logic                              end_of_message,
    input  logic [u16u8_pkg::LIMIT_WIDTH-1:0] output_limit,
    output u16u8_pkg::bundle_t                bundle,
    output logic                              bundle_any
);
    import u16u8_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             first_mark_reg, first_mark_next;
    logic                   big_endian_reg, big_endian_next;
    logic [7:0]             held_byte_reg, held_byte_next;
    logic                   have_held_reg, have_held_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   overflowed_reg, overflowed_next;

    logic [15:0]            unit;
    enc_t                   enc;
    logic [CMP_WIDTH-1:0]   count_plus2;

    assign unit = big_endian_reg ? {held_byte_reg, in_byte} : {in_byte, held_byte_reg};
    assign enc = encode_unit(unit);
    assign count_plus2 = CMP_WIDTH'(count_reg) + CMP_WIDTH'(2);

    always_comb
    begin
        phase_next      = phase_reg;
        first_mark_next = first_mark_reg;
        big_endian_next = big_endian_reg;
        held_byte_next  = held_byte_reg;
        have_held_next  = have_held_reg;
        count_next      = count_reg;
        overflowed_next = overflowed_reg;
        bundle          = '0;

        unique case (phase_reg)
            PH_MARK1:
            begin
                first_mark_next = in_byte;
                phase_next      = PH_MARK2;
            end
            PH_MARK2:
            begin
                if (first_mark_reg == BOM_HI && in_byte == BOM_LO)
                begin
                    big_endian_next = 1'b1;
                    phase_next      = PH_CONV;
                end
                else if (first_mark_reg == BOM_LO && in_byte == BOM_HI)
                begin
                    big_endian_next = 1'b0;
                    phase_next      = PH_CONV;
                end
                else
                begin
                    phase_next = PH_DISCARD;
                end
            end
            PH_CONV:
            begin
                if (!have_held_reg)
                begin
                    held_byte_next = in_byte;
                    have_held_next = 1'b1;
                end
                else
                begin
                    have_held_next = 1'b0;
                    if (!overflowed_reg)
                    begin
                        if (count_plus2 >= CMP_WIDTH'(output_limit))
                        begin
                            overflowed_next = 1'b1;
                        end
                        else
                        begin
                            bundle.data     = enc.data;
                            bundle.num_data = enc.num_data;
                            count_next      = count_reg + COUNT_WIDTH'(enc.num_data);
                        end
                    end
                end
            end
            PH_DISCARD:
            begin
            end
            default:
            begin
            end
        endcase

        if (end_of_message)
        begin
            bundle.has_status = 1'b1;
            if (phase_next != PH_CONV)
                bundle.code = ST_NO_BOM;
            else if (overflowed_next)
                bundle.code = ST_OVERFLOW;
            else
                bundle.code = ST_OK;
            bundle.written  = WRITTEN_WIDTH'(count_next);
            // The message is finished: start over for the next one.
            phase_next      = PH_MARK1;
            first_mark_next = '0;
            big_endian_next = 1'b0;
            held_byte_next  = '0;
            have_held_next  = 1'b0;
            count_next      = '0;
            overflowed_next = 1'b0;
        end
    end

    assign bundle_any = (bundle.num_data != 2'd0) || bundle.has_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MARK1;
            first_mark_reg <= '0;
            big_endian_reg <= 1'b0;
            held_byte_reg  <= '0;
            have_held_reg  <= 1'b0;
            count_reg      <= '0;
            overflowed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            first_mark_reg <= first_mark_next;
            big_endian_reg <= big_endian_next;
            held_byte_reg  <= held_byte_next;
            have_held_reg  <= have_held_next;
            count_reg      <= count_next;
            overflowed_reg <= overflowed_next;
        end
    end

endmodule
